// ===== src/fupd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fupd_pkg: shared types and constants
// Phase codes, character constants, the "file://" prefix table and the
// transfer bundles passed between the decoder stages.
// ----------------------------------------------------------------------------
package fupd_pkg;

    localparam int PREFIX_LEN = 7;
    localparam int WIN_LEN    = 3;
    localparam int SEQ_LEN    = 7;
    localparam int SLOT_CNT   = 8;
    localparam int SLOT_W     = $clog2(SLOT_CNT);

    localparam logic [SLOT_W-1:0] ERR_SLOT = SLOT_W'(SLOT_CNT - 1);

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_COLON   = 8'h3A;

    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_HOST,
        PH_PROBE,
        PH_PATH,
        PH_ERROR
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [SLOT_CNT-1:0]      mask;
        logic [SLOT_CNT-1:0][7:0] data;
        logic                     host;
        logic                     last;
    } burst_t;

    function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
        case (idx)
            3'd0:    return 8'h66;
            3'd1:    return 8'h69;
            3'd2:    return 8'h6C;
            3'd3:    return 8'h65;
            3'd4:    return CH_COLON;
            3'd5:    return CH_SLASH;
            3'd6:    return CH_SLASH;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic is_drive_letter(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]})
        begin
            return c[3:0];
        end
        return c[3:0] + 4'd9;
    endfunction

endpackage
`default_nettype wire

// ===== src/fupd_in_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fupd_in_reg: input register
// Holds one accepted byte until the decode stage takes it.
// ----------------------------------------------------------------------------
module fupd_in_reg
    import fupd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       take,
    output item_t      item
);

    logic       valid_reg, valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       accept;

    assign in_ready = !valid_reg || take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= in_byte;
            last_reg <= in_last;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;
    assign item.last  = last_reg;

endmodule
`default_nettype wire

// ===== src/fupd_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fupd_core: per-byte decode step
// Prefix match, hostname pass-through, drive-spec window and %HH decode.
// Builds the result slots for one byte and updates the parse state.
// ----------------------------------------------------------------------------
module fupd_core
    import fupd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  item_t  item,
    input  logic   take,
    output burst_t burst
);

    phase_t                    phase_reg, phase_next;
    logic [2:0]                pfx_cnt_reg, pfx_cnt_next;
    logic [1:0]                win_cnt_reg, win_cnt_next;
    logic [WIN_LEN-1:0][7:0]   win_reg, win_next;
    logic [1:0]                esc_reg, esc_next;
    logic [3:0]                hi_reg, hi_next;

    logic                      pfx_match;
    logic                      host_done;
    logic                      host_emit;
    logic                      win_mode;
    logic                      path_mode;
    logic [2:0]                hold_cnt;
    logic                      has_b;
    logic [SEQ_LEN-1:0][7:0]   seq;
    logic [2:0]                seq_len;
    logic                      win_full;
    logic                      drive;
    logic                      go;
    logic                      start;

    logic [SEQ_LEN-1:0]        emit;
    logic [SEQ_LEN-1:0][7:0]   dec_val;
    logic [1:0]                esc_end;
    logic [3:0]                hi_end;
    logic                      chain_err;
    logic                      err_end;
    logic [SEQ_LEN-1:0]        res_mask;
    logic                      last_err;

    // raw byte sequence for this step: held bytes, then the new byte
    always_comb
    begin : seq_build
        logic [7:0] src;
        pfx_match = item.data == prefix_byte(pfx_cnt_reg);
        host_done = 1'b0;
        host_emit = 1'b0;
        win_mode  = 1'b0;
        path_mode = 1'b0;
        hold_cnt  = 3'd0;
        has_b     = 1'b0;
        case (phase_reg)
            PH_PREFIX:
            begin
                if (pfx_match)
                begin
                    if (pfx_cnt_reg == 3'(PREFIX_LEN - 1))
                    begin
                        host_done = 1'b1;
                    end
                    else if (item.last)
                    begin
                        win_mode = 1'b1;
                        hold_cnt = pfx_cnt_reg + 3'd1;
                    end
                end
                else
                begin
                    win_mode = 1'b1;
                    hold_cnt = pfx_cnt_reg;
                    has_b    = 1'b1;
                end
            end
            PH_HOST:
            begin
                if (item.data == CH_SLASH)
                begin
                    win_mode = 1'b1;
                    has_b    = 1'b1;
                end
                else
                begin
                    host_emit = 1'b1;
                end
            end
            PH_PROBE:
            begin
                win_mode = 1'b1;
                hold_cnt = {1'b0, win_cnt_reg};
                has_b    = 1'b1;
            end
            PH_PATH:
            begin
                path_mode = 1'b1;
                has_b     = 1'b1;
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < SEQ_LEN; i++)
        begin
            src = (phase_reg == PH_PREFIX) ? prefix_byte(3'(i)) : win_reg[i % WIN_LEN];
            seq[i] = (3'(i) < hold_cnt) ? src : item.data;
        end
        seq_len = hold_cnt + {2'b00, has_b};
    end

    assign win_full = seq_len >= 3'd4;
    assign drive    = is_drive_letter(seq[1]) && (seq[2] == CH_COLON) &&
                      ((seq[3] == CH_SLASH) || (seq[3] == CH_BSLASH));
    assign go       = path_mode || (win_mode && (win_full || item.last));
    assign start    = win_mode && win_full && drive;

    // escape decode over the sequence, stops at the first bad escape
    always_comb
    begin : decode_chain
        logic [1:0] esc;
        logic [3:0] hi;
        logic       err;
        logic [3:0] nib;
        esc     = esc_reg;
        hi      = hi_reg;
        err     = 1'b0;
        emit    = '0;
        dec_val = '0;
        for (int i = 0; i < SEQ_LEN; i++)
        begin
            nib = hex_nibble(seq[i]);
            if (go && !err && (3'(i) >= {2'b00, start}) && (3'(i) < seq_len))
            begin
                if (esc == ESC_IDLE)
                begin
                    if (seq[i] == CH_PERCENT)
                    begin
                        esc = ESC_HIGH;
                    end
                    else
                    begin
                        emit[i]    = 1'b1;
                        dec_val[i] = seq[i];
                    end
                end
                else if (!is_hex(seq[i]))
                begin
                    err = 1'b1;
                end
                else if (esc == ESC_HIGH)
                begin
                    hi  = nib;
                    esc = ESC_LOW;
                end
                else
                begin
                    emit[i]    = 1'b1;
                    dec_val[i] = {hi, nib};
                    esc        = ESC_IDLE;
                end
            end
        end
        esc_end   = esc;
        hi_end    = hi;
        chain_err = err;
    end

    // result slots
    always_comb
    begin
        res_mask    = emit;
        res_mask[0] = emit[0] || host_emit;
        err_end     = chain_err || (phase_reg == PH_ERROR);
        last_err    = item.last && (err_end || host_done || host_emit ||
                                    (esc_end != ESC_IDLE) || (res_mask == '0));
        burst.mask  = {last_err, res_mask};
        for (int i = 0; i < SEQ_LEN; i++)
        begin
            burst.data[i] = dec_val[i];
        end
        burst.data[0]        = host_emit ? item.data : dec_val[0];
        burst.data[ERR_SLOT] = 8'h00;
        burst.host           = host_emit;
        burst.last           = item.last;
    end

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        pfx_cnt_next = pfx_cnt_reg;
        win_cnt_next = win_cnt_reg;
        win_next     = win_reg;
        esc_next     = esc_reg;
        hi_next      = hi_reg;
        if (item.last)
        begin
            phase_next   = PH_PREFIX;
            pfx_cnt_next = 3'd0;
            win_cnt_next = 2'd0;
            esc_next     = ESC_IDLE;
            hi_next      = 4'd0;
        end
        else if (err_end)
        begin
            phase_next = PH_ERROR;
        end
        else if (host_done)
        begin
            phase_next   = PH_HOST;
            pfx_cnt_next = 3'd0;
        end
        else if ((phase_reg == PH_PREFIX) && pfx_match)
        begin
            pfx_cnt_next = pfx_cnt_reg + 3'd1;
        end
        else if (win_mode)
        begin
            pfx_cnt_next = 3'd0;
            if (win_full)
            begin
                phase_next   = PH_PATH;
                win_cnt_next = 2'd0;
                esc_next     = esc_end;
                hi_next      = hi_end;
            end
            else
            begin
                phase_next   = PH_PROBE;
                win_cnt_next = seq_len[1:0];
                for (int i = 0; i < WIN_LEN; i++)
                begin
                    win_next[i] = seq[i];
                end
            end
        end
        else if (path_mode)
        begin
            esc_next = esc_end;
            hi_next  = hi_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_PREFIX;
            pfx_cnt_reg <= 3'd0;
            win_cnt_reg <= 2'd0;
            esc_reg     <= ESC_IDLE;
            hi_reg      <= 4'd0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            pfx_cnt_reg <= pfx_cnt_next;
            win_cnt_reg <= win_cnt_next;
            esc_reg     <= esc_next;
            hi_reg      <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            win_reg <= win_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/fupd_out_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fupd_out_buf: result register
// Holds the result slots of one byte and hands them out lowest slot first.
// ----------------------------------------------------------------------------
module fupd_out_buf
    import fupd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load_req,
    input  burst_t     burst,
    output logic       load,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_is_host,
    output logic       out_error,
    output logic       out_last
);

    logic [SLOT_CNT-1:0]      mask_reg, mask_next;
    logic [SLOT_CNT-1:0][7:0] data_reg;
    logic                     host_reg;
    logic                     last_reg;
    logic [SLOT_W-1:0]        sel;
    logic [SLOT_CNT-1:0]      sel_bit;
    logic                     single;
    logic                     xfer;

    always_comb
    begin
        sel = '0;
        for (int i = SLOT_CNT - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = SLOT_W'(i);
            end
        end
    end

    assign sel_bit   = {{(SLOT_CNT - 1){1'b0}}, 1'b1} << sel;
    assign single    = mask_reg == sel_bit;
    assign out_valid = |mask_reg;
    assign xfer      = out_valid && out_ready;
    assign load      = load_req && (!out_valid || (single && out_ready));

    always_comb
    begin
        mask_next = mask_reg;
        if (load)
        begin
            mask_next = burst.mask;
        end
        else if (xfer)
        begin
            mask_next = mask_reg & ~sel_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= burst.data;
            host_reg <= burst.host;
            last_reg <= burst.last;
        end
    end

    assign out_byte    = data_reg[sel];
    assign out_is_host = host_reg && (sel == '0);
    assign out_error   = sel == ERR_SLOT;
    assign out_last    = last_reg && single;

endmodule
`default_nettype wire

// ===== src/file_uri_percent_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// file_uri_percent_decoder: file URI to local path decoder
// Strips "file://", passes the hostname, drops the slash before a drive
// spec and decodes %HH escapes, one URI byte per transfer.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------
//   in      | in_valid / in_ready  | in_byte, in_last
//   out     | out_valid / out_ready| out_byte, out_is_host, out_error,
//           |                      | out_last
//
// One byte per cycle unless the output stalls; a byte with k results
// holds the input side while the result register drains one per cycle.
// Each byte passes the input register, then the result register.
// Reset clears the parse state and both registers; no clearing pass.
// Either side may stall at any time.
// ----------------------------------------------------------------------------
module file_uri_percent_decoder
    import fupd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_is_host,
    output logic       out_error,
    output logic       out_last
);

    item_t  item;
    burst_t burst;
    logic   take;

    fupd_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .take     (take),
        .item     (item)
    );

    fupd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .take  (take),
        .burst (burst)
    );

    fupd_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_req    (item.valid),
        .burst       (burst),
        .load        (take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .out_is_host (out_is_host),
        .out_error   (out_error),
        .out_last    (out_last)
    );

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_error |-> out_last)
        else $error("error result not marked last");

    a_host_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_is_host |-> !out_last)
        else $error("hostname byte closes a URI");

    a_last_answered: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.last && take |=> out_valid)
        else $error("final byte produced no result");

endmodule
`default_nettype wire
